// ===== sv/tac_pkg.sv =====
// Shared widths, register indexes and status codes for the topocentric altitude converter.
`default_nettype none

package tac_pkg;

  localparam int CoordW   = 28;
  localparam int RefW     = 21;
  localparam int RadiusW  = 27;
  localparam int ResultW  = 34;

  localparam int WideW    = ((CoordW > RadiusW) ? CoordW : RadiusW) + 2;
  localparam int RadW     = 2 * WideW;
  localparam int RootW    = WideW;
  localparam int RemW     = RootW + 3;

  localparam int CfgDataW = (CoordW > RadiusW) ? CoordW : RadiusW;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_REF_ALT   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_RADIUS    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_COORD_MIN = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_COORD_MAX = CfgIdxW'(3);

  localparam logic [RadiusW-1:0] RADIUS_RESET = RadiusW'(101936000);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_NEG    = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== sv/tac_in_if.sv =====
// Input channel of the topocentric altitude converter: coordinates and opcode.
`default_nettype none

interface tac_in_if;
  import tac_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;
  logic signed [CoordW-1:0] altitude_in;

  modport source (
    output valid, opcode, coord_x, coord_y, coord_z, altitude_in,
    input  ready
  );

  modport sink (
    input  valid, opcode, coord_x, coord_y, coord_z, altitude_in,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/tac_out_if.sv =====
// Output channel of the topocentric altitude converter: result value and status.
`default_nettype none

interface tac_out_if;
  import tac_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ResultW-1:0] result_value;
  logic [1:0]                status;

  modport source (
    output valid, result_value, status,
    input  ready
  );

  modport sink (
    input  valid, result_value, status,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/topocentric_altitude_convert.sv =====
// Top level: pipelined altitude / y-coordinate converter on a spherical earth.
//
// Usage:
//   Input transfers on in_i carry opcode, coord_x/y/z and altitude_in; each
//   produces exactly one transfer on out_o with result_value and status.
//   Opcode 0 gives altitude, opcode 1 gives the y coordinate at that altitude.
//   Status 1 flags a coordinate outside coord_min..coord_max, status 2 a
//   negative radicand; result_value is zero whenever status is not zero.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
//   clock edge; issue them only while no item is in flight.
// Timing:
//   Stages: one for bounds and offsets, one for the three squares, one for
//   the radicand, one per result bit of the square root (RootW stages) and
//   the output register. Throughput is one item per cycle while out_o does
//   not stall.
// Reset and stall:
//   Reset empties the pipeline and loads the default radius and full bounds.
//   When out_o stalls, one more item drains into a skid register; after that
//   in_i.ready drops and the whole pipeline holds until the output moves.
`default_nettype none

module topocentric_altitude_convert (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tac_pkg::CfgDataW-1:0] cfg_data_i,
  tac_in_if.sink                       in_i,
  tac_out_if.source                    out_o
);
  import tac_pkg::*;

  // configuration registers
  logic signed [RefW-1:0]   ref_q;
  logic [RadiusW-1:0]       radius_q;
  logic signed [CoordW-1:0] cmin_q;
  logic signed [CoordW-1:0] cmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= '0;
      radius_q <= RADIUS_RESET;
      cmin_q   <= {1'b1, {(CoordW-1){1'b0}}};
      cmax_q   <= {1'b0, {(CoordW-1){1'b1}}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REF_ALT:   ref_q    <= signed'(cfg_data_i[RefW-1:0]);
        CFG_RADIUS:    radius_q <= cfg_data_i[RadiusW-1:0];
        CFG_COORD_MIN: cmin_q   <= signed'(cfg_data_i[CoordW-1:0]);
        CFG_COORD_MAX: cmax_q   <= signed'(cfg_data_i[CoordW-1:0]);
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves whenever the skid register is empty
  logic skid_v_q;
  logic adv;

  assign adv        = !skid_v_q;
  assign in_i.ready = adv;

  // stage 1: bounds check and offset sums
  logic signed [WideW-1:0] y_w, a_w, ref_w, r_w, w_d;
  logic                    bx, by, bz, oob_d;

  always_comb begin
    y_w   = WideW'(in_i.coord_y);
    a_w   = WideW'(in_i.altitude_in);
    ref_w = WideW'(ref_q);
    r_w   = signed'({{(WideW-RadiusW){1'b0}}, radius_q});
    w_d   = in_i.opcode ? (a_w + r_w) : (y_w + ref_w + r_w);
    bx    = (in_i.coord_x >= cmin_q) && (in_i.coord_x <= cmax_q);
    by    = (in_i.coord_y >= cmin_q) && (in_i.coord_y <= cmax_q);
    bz    = (in_i.coord_z >= cmin_q) && (in_i.coord_z <= cmax_q);
    oob_d = !(bx && bz && (in_i.opcode || by));
  end

  logic                     p1_v_q, p1_op_q, p1_oob_q;
  logic signed [CoordW-1:0] p1_x_q, p1_z_q;
  logic signed [WideW-1:0]  p1_w_q;

  // stage 2: squares
  logic                       p2_v_q, p2_op_q, p2_oob_q;
  logic signed [2*CoordW-1:0] p2_xx_q, p2_zz_q;
  logic signed [RadW-1:0]     p2_ww_q;

  // stage 3: radicand and status
  logic signed [RadW-1:0] xx_e, zz_e, rad_d;
  status_e                st_d;

  always_comb begin
    xx_e  = RadW'(p2_xx_q);
    zz_e  = RadW'(p2_zz_q);
    rad_d = p2_op_q ? (p2_ww_q - xx_e - zz_e) : (p2_ww_q + xx_e + zz_e);
    if (p2_oob_q) begin
      st_d = ST_BOUNDS;
    end else if (p2_op_q && rad_d[RadW-1]) begin
      st_d = ST_NEG;
    end else begin
      st_d = ST_OK;
    end
  end

  logic            p3_v_q, p3_op_q;
  status_e         p3_st_q;
  logic [RadW-1:0] p3_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= in_i.valid;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_op_q  <= in_i.opcode;
      p1_oob_q <= oob_d;
      p1_x_q   <= in_i.coord_x;
      p1_z_q   <= in_i.coord_z;
      p1_w_q   <= w_d;
      p2_op_q  <= p1_op_q;
      p2_oob_q <= p1_oob_q;
      p2_xx_q  <= p1_x_q * p1_x_q;
      p2_zz_q  <= p1_z_q * p1_z_q;
      p2_ww_q  <= p1_w_q * p1_w_q;
      p3_op_q  <= p2_op_q;
      p3_st_q  <= st_d;
      p3_rad_q <= (st_d == ST_OK) ? unsigned'(rad_d) : '0;
    end
  end

  // square root: one result bit per stage
  logic [RemW-1:0]  sq_rem_q  [RootW];
  logic [RootW-1:0] sq_root_q [RootW];
  logic [RadW-1:0]  sq_rad_q  [RootW];
  logic             sq_op_q   [RootW];
  status_e          sq_st_q   [RootW];
  logic [RootW-1:0] sq_v_q;

  for (genvar j = 0; j < RootW; j++) begin : g_sq
    logic [RemW-1:0]  rem_in, rem_sh, trial;
    logic [RootW-1:0] root_in;
    logic [RadW-1:0]  rad_in;
    logic             op_in, v_in, ge;
    status_e          st_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = p3_rad_q;
      assign op_in   = p3_op_q;
      assign st_in   = p3_st_q;
      assign v_in    = p3_v_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
      assign rad_in  = sq_rad_q[j-1];
      assign op_in   = sq_op_q[j-1];
      assign st_in   = sq_st_q[j-1];
      assign v_in    = sq_v_q[j-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j] <= 1'b0;
      end else if (adv) begin
        sq_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[j]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_q[j] <= {root_in[RootW-2:0], ge};
        sq_rad_q[j]  <= {rad_in[RadW-3:0], 2'b00};
        sq_op_q[j]   <= op_in;
        sq_st_q[j]   <= st_in;
      end
    end
  end

  // final offset and output register with skid
  logic                      v_f, op_f;
  status_e                   st_f;
  logic signed [ResultW-1:0] off_w, res_w, val_f;

  always_comb begin
    v_f   = sq_v_q[RootW-1];
    op_f  = sq_op_q[RootW-1];
    st_f  = sq_st_q[RootW-1];
    off_w = op_f ? (ResultW'(ref_q) + signed'(ResultW'(radius_q)))
                 : signed'(ResultW'(radius_q));
    res_w = signed'(ResultW'(sq_root_q[RootW-1])) - off_w;
    val_f = (st_f == ST_OK) ? res_w : '0;
  end

  logic                      out_v_q;
  logic signed [ResultW-1:0] out_val_q, skid_val_q;
  status_e                   out_st_q, skid_st_q;
  logic                      take;

  assign take = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (adv) begin
      if (take) begin
        out_v_q <= v_f;
      end else if (v_f) begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (take) begin
        out_val_q <= val_f;
        out_st_q  <= st_f;
      end else begin
        skid_val_q <= val_f;
        skid_st_q  <= st_f;
      end
    end else if (take) begin
      out_val_q <= skid_val_q;
      out_st_q  <= skid_st_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.result_value = out_val_q;
  assign out_o.status       = out_st_q;

endmodule

`default_nettype wire

// ===== sv/tac_checker.sv =====
// Port-level checker for the topocentric altitude converter and its bind.
`default_nettype none

module tac_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [tac_pkg::ResultW-1:0] out_result_i,
  input logic [1:0]                         out_status_i
);
  import tac_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_result_i) && $stable(out_status_i))
    else $error("output dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> out_result_i == '0)
    else $error("nonzero result with error status");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && $past(out_valid_i && !out_ready_i))
    else $error("input held off without an output stall");

  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i)
    else $error("input not ready after output transfer");

endmodule

bind topocentric_altitude_convert tac_checker u_tac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result_value),
  .out_status_i (out_o.status)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the topocentric altitude converter: directed table, random items, self-checking.
`timescale 1ns / 100ps

module testbench;
  import tac_pkg::*;

  localparam int     Latency    = RootW + 4;
  localparam int     CycleLimit = 400000;
  localparam int     NumDir     = 25;
  localparam int     NumSeg     = 10;
  localparam int     SegItems   = 155;
  localparam longint CMax       = 134217727;
  localparam longint CMin       = -134217728;
  localparam longint RefMax     = 1048575;
  localparam longint RefMin     = -1048576;
  localparam longint RadMax     = 134217727;
  localparam longint RadDef     = 101936000;

  typedef struct {
    logic signed [ResultW-1:0] value;
    status_e                   status;
  } conv_result_t;

  typedef struct {
    longint ref_alt;
    longint radius;
    longint cmin;
    longint cmax;
  } setting_t;

  typedef struct {
    int      phase;
    logic    op;
    longint  x;
    longint  y;
    longint  z;
    longint  alt;
    bit      known;
    longint  value;
    status_e status;
  } step_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tac_in_if  in_bus ();
  tac_out_if out_bus ();

  topocentric_altitude_convert DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  longint ref_q;
  longint radius_q;
  longint cmin_q;
  longint cmax_q;

  conv_result_t awaited_results[$];
  int errors;
  int burst_left;

  setting_t phase_cfg [4] = '{
    '{0,      RadDef, CMin,  CMax},
    '{RefMax, RadMax, -1000, 1000},
    '{RefMin, 0,      5,     -5},
    '{RefMin, 0,      CMin,  CMax}
  };

  step_t steps [NumDir] = '{
    '{0, 1'b0, 0,     0,          0,     0,          1, 0,          ST_OK},
    '{0, 1'b1, 0,     0,          0,     0,          1, 0,          ST_OK},
    '{0, 1'b0, CMax,  CMax,       CMax,  0,          0, 0,          ST_OK},
    '{0, 1'b0, CMin,  CMin,       CMin,  0,          0, 0,          ST_OK},
    '{0, 1'b1, CMax,  CMax,       CMax,  0,          1, 0,          ST_NEG},
    '{0, 1'b1, CMin,  0,          CMin,  CMax,       0, 0,          ST_OK},
    '{0, 1'b1, 0,     0,          0,     CMin,       0, 0,          ST_OK},
    '{0, 1'b1, 1,     0,          0,     -RadDef,    1, 0,          ST_NEG},
    '{0, 1'b1, 0,     0,          0,     -RadDef,    1, -RadDef,    ST_OK},
    '{0, 1'b0, 0,     -RadDef,    0,     0,          1, -RadDef,    ST_OK},
    '{0, 1'b0, 3,     0,          4,     0,          0, 0,          ST_OK},
    '{1, 1'b0, 1001,  0,          0,     0,          1, 0,          ST_BOUNDS},
    '{1, 1'b0, 0,     -1001,      0,     0,          1, 0,          ST_BOUNDS},
    '{1, 1'b0, -1000, 1000,       1000,  0,          0, 0,          ST_OK},
    '{1, 1'b1, 0,     CMax,       0,     0,          0, 0,          ST_OK},
    '{1, 1'b1, 0,     0,          -1001, 0,          1, 0,          ST_BOUNDS},
    '{1, 1'b1, 1001,  0,          0,     -RadMax,    1, 0,          ST_BOUNDS},
    '{1, 1'b1, 1000,  0,          -1000, CMax,       0, 0,          ST_OK},
    '{2, 1'b0, 0,     0,          0,     0,          1, 0,          ST_BOUNDS},
    '{2, 1'b1, 0,     0,          0,     0,          1, 0,          ST_BOUNDS},
    '{3, 1'b0, CMax,  CMin,       CMin,  0,          0, 0,          ST_OK},
    '{3, 1'b1, 0,     0,          0,     0,          1, -RefMin,    ST_OK},
    '{3, 1'b1, 1,     0,          0,     0,          1, 0,          ST_NEG},
    '{3, 1'b1, CMax,  CMin,       CMin,  CMin,       0, 0,          ST_OK},
    '{3, 1'b0, CMin,  CMin,       CMin,  CMin,       0, 0,          ST_OK}
  };

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic bit coord_ok(longint c);
    return c >= cmin_q && c <= cmax_q;
  endfunction

  function automatic conv_result_t convert(logic op, longint x, longint y, longint z,
                                           longint alt);
    conv_result_t res;
    longint s;
    longint rad;
    res.value  = '0;
    res.status = ST_OK;
    if (!coord_ok(x) || !coord_ok(z) || (op == 1'b0 && !coord_ok(y))) begin
      res.status = ST_BOUNDS;
    end else if (op == 1'b0) begin
      s   = y + ref_q + radius_q;
      rad = x * x + z * z + s * s;
      res.value = ResultW'(longint'(root_floor(rad)) - radius_q);
    end else begin
      s   = alt + radius_q;
      rad = s * s - x * x - z * z;
      if (rad < 0) res.status = ST_NEG;
      else res.value = ResultW'(longint'(root_floor(rad)) - ref_q - radius_q);
    end
    return res;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > CMax) return CMax;
    if (v < CMin) return CMin;
    return v;
  endfunction

  function automatic longint rand_field();
    logic signed [CoordW-1:0] v;
    v = CoordW'($urandom);
    return longint'(v);
  endfunction

  function automatic longint rand_span(int lo_k, int hi_k);
    longint lim;
    lim = longint'(1) << $urandom_range(lo_k, hi_k);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic longint rand_coord();
    longint base;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_field();
      4, 5, 6: return rand_span(4, 20);
      7: begin
        case ($urandom_range(0, 4))
          0: return CMin;
          1: return CMax;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      default: begin
        base = $urandom_range(0, 1) ? cmin_q : cmax_q;
        return clamp_coord(base + longint'($urandom_range(0, 2)) - 1);
      end
    endcase
  endfunction

  function automatic longint rand_altitude();
    if ($urandom_range(0, 4) == 0) return clamp_coord(rand_span(2, 16) - radius_q);
    return rand_coord();
  endfunction

  function automatic setting_t pick_setting(int seg);
    setting_t s;
    logic signed [RefW-1:0] r21;
    longint a;
    longint b;
    r21 = RefW'($urandom);
    s.ref_alt = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? RefMax : RefMin)
                                            : longint'(r21);
    case ($urandom_range(0, 3))
      0, 1: s.radius = RadDef + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      2: s.radius = longint'(RadiusW'($urandom));
      default: s.radius = $urandom_range(0, 1) ? RadMax : 0;
    endcase
    a = rand_field();
    b = rand_field();
    case ($urandom_range(0, 5))
      0, 1: begin
        s.cmin = CMin;
        s.cmax = CMax;
      end
      2, 3: begin
        s.cmin = (a < b) ? a : b;
        s.cmax = (a < b) ? b : a;
      end
      4: begin
        s.cmin = -longint'($urandom_range(0, 1 << 24));
        s.cmax = longint'($urandom_range(0, 1 << 24));
      end
      default: begin
        s.cmin = a;
        s.cmax = b;
      end
    endcase
    case (seg)
      0: s = '{RefMax, RadMax, CMin, CMax};
      1: s = '{RefMin, 0, CMin, CMax};
      2: s = '{0, RadDef, CMin, CMax};
      3: begin
        s.cmin = CMax;
        s.cmax = CMax;
      end
      4: begin
        s.cmin = CMin;
        s.cmax = CMin;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string what, longint expected, longint actual);
    $display("mismatch %s: expected %0d, got %0d", what, expected, actual);
    errors++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    logic signed [RefW-1:0]   r21;
    logic signed [CoordW-1:0] c28;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    r21 = d[RefW-1:0];
    c28 = d[CoordW-1:0];
    case (idx)
      CFG_REF_ALT:   ref_q    = longint'(r21);
      CFG_RADIUS:    radius_q = longint'(d[RadiusW-1:0]);
      CFG_COORD_MIN: cmin_q   = longint'(c28);
      CFG_COORD_MAX: cmax_q   = longint'(c28);
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'($urandom);
    d[RefW-1:0] = RefW'(s.ref_alt);
    write_reg(CFG_REF_ALT, d);
    d = CfgDataW'($urandom);
    d[RadiusW-1:0] = RadiusW'(s.radius);
    write_reg(CFG_RADIUS, d);
    write_reg(CFG_COORD_MIN, CfgDataW'(s.cmin));
    write_reg(CFG_COORD_MAX, CfgDataW'(s.cmax));
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic send_item(logic op, longint x, longint y, longint z, longint alt,
                           bit known, longint value, status_e status);
    logic signed [CoordW-1:0] xs;
    logic signed [CoordW-1:0] ys;
    logic signed [CoordW-1:0] zs;
    logic signed [CoordW-1:0] as;
    conv_result_t res;
    int gap;
    xs = CoordW'(x);
    ys = CoordW'(y);
    zs = CoordW'(z);
    as = CoordW'(alt);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= op;
    in_bus.coord_x     <= xs;
    in_bus.coord_y     <= ys;
    in_bus.coord_z     <= zs;
    in_bus.altitude_in <= as;
    do @(posedge clk); while (!in_bus.ready);
    if (known) begin
      res.value  = ResultW'(value);
      res.status = status;
    end else begin
      res = convert(op, longint'(xs), longint'(ys), longint'(zs), longint'(as));
    end
    awaited_results.push_back(res);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin : receiver
    conv_result_t want;
    int mode;
    int mode_left;
    int tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected transfer, value", 0, longint'(out_bus.result_value));
        end else begin
          want = awaited_results.pop_front();
          if (out_bus.result_value !== want.value)
            report_mismatch("result_value", longint'(want.value),
                            longint'(out_bus.result_value));
          if (out_bus.status !== want.status)
            report_mismatch("status", longint'(want.status), longint'(out_bus.status));
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= 1'($urandom_range(0, 1));
        2: out_bus.ready <= ($urandom_range(0, 7) == 0);
        default: out_bus.ready <= (tick % 8) < 3;
      endcase
    end
  end

  initial begin : stimulus
    step_t row;
    int cur_phase;
    logic op;
    longint cx;
    longint cy;
    longint cz;
    longint ca;
    errors     = 0;
    burst_left = 0;
    ref_q      = 0;
    radius_q   = RadDef;
    cmin_q     = CMin;
    cmax_q     = CMax;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_REF_ALT;
    cfg_data   <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.opcode      <= 1'b0;
    in_bus.coord_x     <= '0;
    in_bus.coord_y     <= '0;
    in_bus.coord_z     <= '0;
    in_bus.altitude_in <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_phase = 0;
    for (int i = 0; i < NumDir; i++) begin
      row = steps[i];
      if (row.phase != cur_phase) begin
        settle();
        apply_setting(phase_cfg[row.phase]);
        cur_phase = row.phase;
      end
      send_item(row.op, row.x, row.y, row.z, row.alt, row.known, row.value, row.status);
    end

    for (int seg = 0; seg < NumSeg; seg++) begin
      settle();
      apply_setting(pick_setting(seg));
      repeat (SegItems) begin
        op = 1'($urandom_range(0, 1));
        cx = rand_coord();
        cy = rand_coord();
        cz = rand_coord();
        ca = rand_altitude();
        send_item(op, cx, cy, cz, ca, 1'b0, 0, ST_OK);
      end
    end

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tac_pkg.sv
sv/tac_in_if.sv
sv/tac_out_if.sv
sv/topocentric_altitude_convert.sv
sv/tac_checker.sv
test/testbench.sv
